// File: hw/rtl/blsb_pkg.sv
// Shared types, constants and bit-deposit helpers for the block-linear blit address generator.
// Used by every module of the block; depends on nothing else.
package blsb_pkg;

  localparam int AddrBits    = 22;
  localparam int PaddedWidth = 1280;
  localparam int YOffBits    = 11;
  localparam int TileRowsLog2 = 7;
  localparam int CfgDataBits = 13;
  localparam int ColBits     = 12;
  localparam int RowBits     = 10;

  // Y coordinate bits occupy address positions 2, 4, 5 and 7 to 10.
  localparam logic [YOffBits-1:0] YMask  = 11'h7B4;
  localparam logic [AddrBits-1:0] XMask  = ~AddrBits'(32'h7B4);

  localparam logic [12:0] MaxWidth  = 13'd4096;
  localparam logic [10:0] MaxHeight = 11'd1024;

  typedef enum logic [1:0] {
    REG_RECT_WIDTH  = 2'd0,
    REG_RECT_HEIGHT = 2'd1,
    REG_ORIGIN_X    = 2'd2,
    REG_ORIGIN_Y    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic                done;
  } blsb_result_t;

  // Scatter the low bits of v, in order, onto the set bits of XMask.
  function automatic logic [AddrBits-1:0] deposit_x(input logic [31:0] v);
    logic [AddrBits-1:0] res;
    int                  k;
    res = '0;
    k   = 0;
    for (int pos = 0; pos < AddrBits; pos++) begin
      if (XMask[pos]) begin
        res[pos] = v[k];
        k        = k + 1;
      end
    end
    return res;
  endfunction

  // Scatter the low bits of v onto the set bits of YMask.
  function automatic logic [YOffBits-1:0] deposit_y(input logic [TileRowsLog2-1:0] v);
    logic [YOffBits-1:0] res;
    int                  k;
    res = '0;
    k   = 0;
    for (int pos = 0; pos < YOffBits; pos++) begin
      if (YMask[pos]) begin
        res[pos] = v[k];
        k        = k + 1;
      end
    end
    return res;
  endfunction

  // X offset step for one tile row of the padded surface width.
  localparam logic [AddrBits-1:0] IncrRow = deposit_x(32'(PaddedWidth));

endpackage

// File: hw/rtl/blsb_addr_gen.sv
// Position counters and swizzled x/y offset registers; forms the tiled address of each pixel.
// Depends on blsb_pkg.
module blsb_addr_gen
  import blsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [12:0]        rect_width,
  input  logic [10:0]        rect_height,
  input  logic [11:0]        origin_x,
  input  logic [9:0]         origin_y,
  output blsb_result_t       result
);

  logic                started;
  logic [ColBits-1:0]  col_count;
  logic [RowBits-1:0]  row_count;
  logic [AddrBits-1:0] x_offset;
  logic [AddrBits-1:0] row_start_offset;
  logic [YOffBits-1:0] y_offset;

  logic                started_next;
  logic [ColBits-1:0]  col_count_next;
  logic [RowBits-1:0]  row_count_next;
  logic [AddrBits-1:0] x_offset_next;
  logic [AddrBits-1:0] row_start_offset_next;
  logic [YOffBits-1:0] y_offset_next;

  logic [AddrBits-1:0] x_start;
  logic [YOffBits-1:0] y_start;
  logic [AddrBits-1:0] x_cur;
  logic [AddrBits-1:0] rs_cur;
  logic [YOffBits-1:0] y_cur;
  logic [ColBits-1:0]  col_cur;
  logic [RowBits-1:0]  row_cur;
  logic [12:0]         w_eff;
  logic [10:0]         h_eff;
  logic                last_col;
  logic                last_row;
  logic [YOffBits-1:0] y_step;
  logic [AddrBits-1:0] rs_step;

  // Offsets a new rectangle starts from, derived from the origin registers.
  assign x_start = deposit_x(32'(origin_x)) +
                   IncrRow * AddrBits'(origin_y[RowBits-1:TileRowsLog2]);
  assign y_start = deposit_y(origin_y[TileRowsLog2-1:0]);

  assign x_cur   = started ? x_offset         : x_start;
  assign rs_cur  = started ? row_start_offset : x_start;
  assign y_cur   = started ? y_offset         : y_start;
  assign col_cur = started ? col_count        : '0;
  assign row_cur = started ? row_count        : '0;

  always_comb begin
    if (rect_width == '0) begin
      w_eff = 13'd1;
    end else if (rect_width > MaxWidth) begin
      w_eff = MaxWidth;
    end else begin
      w_eff = rect_width;
    end
    if (rect_height == '0) begin
      h_eff = 11'd1;
    end else if (rect_height > MaxHeight) begin
      h_eff = MaxHeight;
    end else begin
      h_eff = rect_height;
    end
  end

  assign last_col = ({1'b0, col_cur} + 13'd1) >= w_eff;
  assign last_row = ({1'b0, row_cur} + 11'd1) >= h_eff;

  assign result.addr = AddrBits'(y_cur) + x_cur;
  assign result.done = last_col && last_row;

  // Masked increment: the borrow ripples across the unmasked gaps.
  assign y_step  = (y_cur - YMask) & YMask;
  assign rs_step = (y_step == '0) ? rs_cur + IncrRow : rs_cur;

  always_comb begin
    started_next          = 1'b1;
    col_count_next        = col_cur;
    row_count_next        = row_cur;
    x_offset_next         = x_cur;
    row_start_offset_next = rs_cur;
    y_offset_next         = y_cur;
    if (!last_col) begin
      col_count_next = col_cur + ColBits'(1);
      x_offset_next  = (x_cur - XMask) & XMask;
    end else if (!last_row) begin
      col_count_next        = '0;
      row_count_next        = row_cur + RowBits'(1);
      y_offset_next         = y_step;
      row_start_offset_next = rs_step;
      x_offset_next         = rs_step;
    end else begin
      col_count_next = '0;
      row_count_next = '0;
      started_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      col_count        <= '0;
      row_count        <= '0;
      x_offset         <= '0;
      row_start_offset <= '0;
      y_offset         <= '0;
    end else if (advance) begin
      started          <= started_next;
      col_count        <= col_count_next;
      row_count        <= row_count_next;
      x_offset         <= x_offset_next;
      row_start_offset <= row_start_offset_next;
      y_offset         <= y_offset_next;
    end
  end

endmodule

// File: hw/rtl/blsb_out_reg.sv
// Result register holding one finished transaction until the receiver takes it.
// Depends on blsb_pkg.
module blsb_out_reg
  import blsb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  blsb_result_t        result,
  input  logic [31:0]         pixel,
  input  logic                out_ready,
  output logic                can_load,
  output logic                out_valid,
  output logic [AddrBits-1:0] dest_addr,
  output logic [31:0]         dest_pixel,
  output logic                rect_done
);

  // A new result may enter when the register is empty or is emptied this cycle.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_addr  <= result.addr;
      dest_pixel <= pixel;
      rect_done  <= result.done;
    end
  end

endmodule

// File: hw/rtl/block_linear_swizzle_blit_addr.sv
// Block-linear tiled address generator for a rectangle blit.
// Instantiates blsb_addr_gen and blsb_out_reg; depends on blsb_pkg.
//
// Source pixels enter on the in_valid/in_ready channel in row-major order.
// Every accepted pixel produces exactly one transaction on the out channel:
// the word address of the pixel in the tiled surface, the pixel itself and
// rect_done, which is high on the last pixel of the rectangle.
// A pixel accepted in one cycle is shown on the outputs in the next. Throughput
// is one pixel per cycle unless the receiver stalls, set by the single result
// register; the address and counter update is one masked add per step.
// in_ready is high whenever the result register is empty or is being taken,
// so a stalled receiver holds the result and stalls the source one-for-one.
// The configuration port writes rect_width, rect_height, origin_x and
// origin_y by index; write them only while no transaction is in flight.
// The origin is taken at the first pixel of each rectangle; sizes are live.
// Reset loads the default 1280 by 720 size at origin zero, empties the result
// register and starts a fresh rectangle.
module block_linear_swizzle_blit_addr
  import blsb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            src_pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [AddrBits-1:0]    dest_addr,
  output logic [31:0]            dest_pixel,
  output logic                   rect_done
);

  logic [12:0]  rect_width;
  logic [10:0]  rect_height;
  logic [11:0]  origin_x;
  logic [9:0]   origin_y;
  logic         accept;
  blsb_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width  <= 13'd1280;
      rect_height <= 11'd720;
      origin_x    <= '0;
      origin_y    <= '0;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_RECT_WIDTH:  rect_width  <= cfg_data[12:0];
        REG_RECT_HEIGHT: rect_height <= cfg_data[10:0];
        REG_ORIGIN_X:    origin_x    <= cfg_data[11:0];
        REG_ORIGIN_Y:    origin_y    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  blsb_addr_gen u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .result      (result)
  );

  blsb_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result     (result),
    .pixel      (src_pixel),
    .out_ready  (out_ready),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .dest_addr  (dest_addr),
    .dest_pixel (dest_pixel),
    .rect_done  (rect_done)
  );

endmodule

// File: hw/rtl/blsb_checker.sv
// Port-level checks for the blit address generator, bound to its top level.
// Depends on blsb_pkg and block_linear_swizzle_blit_addr.
module blsb_checker
  import blsb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [31:0]         src_pixel,
  input logic                out_valid,
  input logic                out_ready,
  input logic [AddrBits-1:0] dest_addr,
  input logic [31:0]         dest_pixel,
  input logic                rect_done
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dest_addr) &&
      $stable(dest_pixel) && $stable(rect_done))
    else $error("stalled result changed");

  // The block never refuses a pixel while its result register is empty.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // An accepted pixel appears on the outputs in the next cycle, unchanged.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && dest_pixel == $past(src_pixel))
    else $error("accepted pixel not forwarded");

  // A taken result with nothing new behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated");

  // Reset empties the output.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind block_linear_swizzle_blit_addr blsb_checker u_blsb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .src_pixel  (src_pixel),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .dest_addr  (dest_addr),
  .dest_pixel (dest_pixel),
  .rect_done  (rect_done)
);
